/* hdl/qenc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register indexes and types of the quadrature encoder counter.
// Used by qenc_lane, qenc_merge and quad_encoder_counter_snapshot_unit.
package qenc_pkg;

    localparam int NCH             = 4;   // channel ports of the block
    localparam int NARROW_BITS     = 16;  // counter width of channels 1 and 3
    localparam int WIDE_OUT        = 32;  // delta width of channels 0 and 2
    localparam int NARROW_OUT      = 17;  // delta width of channels 1 and 3
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 32;

    localparam int CHANNELS_DEF       = 4;
    localparam int FILTER_SAMPLES_DEF = 8;
    localparam int COUNTER_BITS_DEF   = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CH0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CH1 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CH2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CH3 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT  = 3'd4;

    // Per-tick control handed to every lane.
    typedef struct packed {
        logic step;   // a sample tick is taken this cycle
        logic clear;  // the tick also reports, so the counter clears afterwards
    } lane_ctl_t;

endpackage

/* hdl/quad_encoder_counter_snapshot_unit.sv */
`timescale 1ns / 1ps
// Four-channel x4 quadrature encoder counter with read-and-clear report.
// Accepts one sample per cycle unless stalled; all channel lanes update in that cycle.
// A report appears in the output register in the cycle after its transaction.
// Input stalls only for a reporting transaction while an earlier report is still held.
// Reset clears counters, filters and output valid; limits reload to all ones, invert to 0.
module quad_encoder_counter_snapshot_unit
    import qenc_pkg::*;
#(
    parameter int CHANNELS       = CHANNELS_DEF,
    parameter int FILTER_SAMPLES = FILTER_SAMPLES_DEF,
    parameter int COUNTER_BITS   = COUNTER_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [NCH-1:0]                phase_a_levels,
    input  logic [NCH-1:0]                phase_b_levels,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [WIDE_OUT-1:0]    delta_ch0,
    output logic signed [NARROW_OUT-1:0]  delta_ch1,
    output logic signed [WIDE_OUT-1:0]    delta_ch2,
    output logic signed [NARROW_OUT-1:0]  delta_ch3,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    logic [COUNTER_BITS-1:0]      max0_reg;
    logic [NARROW_BITS-1:0]       max1_reg;
    logic [COUNTER_BITS-1:0]      max2_reg;
    logic [NARROW_BITS-1:0]       max3_reg;
    logic [NCH-1:0]               invert_reg;
    logic [NCH-1:0][WIDE_OUT-1:0] max_all;
    logic [NCH-1:0][WIDE_OUT-1:0] snap;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         accept;
    logic                         report;
    lane_ctl_t                    ctl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max0_reg   <= '1;
            max1_reg   <= '1;
            max2_reg   <= '1;
            max3_reg   <= '1;
            invert_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_CH0: max0_reg   <= cfg_data[COUNTER_BITS-1:0];
                REG_MAX_CH1: max1_reg   <= cfg_data[NARROW_BITS-1:0];
                REG_MAX_CH2: max2_reg   <= cfg_data[COUNTER_BITS-1:0];
                REG_MAX_CH3: max3_reg   <= cfg_data[NARROW_BITS-1:0];
                REG_INVERT:  invert_reg <= cfg_data[NCH-1:0];
                default:     ;
            endcase
        end
    end

    assign max_all[0] = WIDE_OUT'(max0_reg);
    assign max_all[1] = WIDE_OUT'(max1_reg);
    assign max_all[2] = WIDE_OUT'(max2_reg);
    assign max_all[3] = WIDE_OUT'(max3_reg);

    // Only a reporting transaction needs the output register, so plain samples keep flowing.
    assign in_stall = out_valid_reg && out_stall && func;
    assign accept   = in_valid && !in_stall;
    assign report   = accept && func;

    assign ctl.step  = accept;
    assign ctl.clear = func;

    for (genvar ch = 0; ch < NCH; ch++)
    begin : g_lane
        localparam int W = (ch % 2 == 1) ? NARROW_BITS : COUNTER_BITS;
        if (ch < CHANNELS)
        begin : g_on
            logic [W-1:0] count;

            qenc_lane #(
                .WIDTH          (W),
                .FILTER_SAMPLES (FILTER_SAMPLES)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .raw_a     (phase_a_levels[ch]),
                .raw_b     (phase_b_levels[ch]),
                .max_count (max_all[ch][W-1:0]),
                .count     (count)
            );

            assign snap[ch] = WIDE_OUT'(count);
        end
        else
        begin : g_off
            assign snap[ch] = '0;
        end
    end

    qenc_merge #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_merge (
        .clk       (clk),
        .load      (report),
        .snap      (snap),
        .invert    (invert_reg),
        .delta_ch0 (delta_ch0),
        .delta_ch1 (delta_ch1),
        .delta_ch2 (delta_ch2),
        .delta_ch3 (delta_ch3)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (report)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;

    // A held report is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(report && out_valid_reg && out_stall))
        else $error("report accepted over a held result");

    a_report_shows: assert property (@(posedge clk) disable iff (!rst_n)
        report |=> out_valid)
        else $error("accepted report did not reach the output");

    a_taken_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !report) |=> !out_valid)
        else $error("taken result was repeated");

endmodule

/* hdl/qenc_lane.sv */
`timescale 1ns / 1ps
// One encoder channel: two phase filters and the x4 up/down wrap counter.
// Depends on qenc_pkg for lane_ctl_t and the parameter defaults.
module qenc_lane
    import qenc_pkg::*;
#(
    parameter int WIDTH          = COUNTER_BITS_DEF,
    parameter int FILTER_SAMPLES = FILTER_SAMPLES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctl_t        ctl,
    input  logic             raw_a,
    input  logic             raw_b,
    input  logic [WIDTH-1:0] max_count,
    output logic [WIDTH-1:0] count
);

    localparam int RUN_W = (FILTER_SAMPLES > 1) ? $clog2(FILTER_SAMPLES) : 1;
    localparam logic [RUN_W:0] FS_V = (RUN_W + 1)'(FILTER_SAMPLES);
    localparam logic [RUN_W:0] ONE_V = (RUN_W + 1)'(1);

    logic [1:0]            filt_reg;
    logic [1:0]            filt_next;
    logic [1:0][RUN_W-1:0] run_reg;
    logic [1:0][RUN_W-1:0] run_next;
    logic [WIDTH-1:0]      cnt_reg;
    logic [WIDTH-1:0]      counted;
    logic [1:0]            raw;
    logic                  chg_a;
    logic                  chg_b;
    logic                  up;

    always_comb
    begin
        raw = {raw_b, raw_a};
        for (int p = 0; p < 2; p++)
        begin
            if (raw[p] == filt_reg[p])
            begin
                run_next[p]  = '0;
                filt_next[p] = filt_reg[p];
            end
            else if (({1'b0, run_reg[p]} + ONE_V) >= FS_V)
            begin
                run_next[p]  = '0;
                filt_next[p] = raw[p];
            end
            else
            begin
                run_next[p]  = run_reg[p] + RUN_W'(1);
                filt_next[p] = filt_reg[p];
            end
        end
    end

    // An edge on one phase counts by the level of the other; a double edge counts nothing.
    always_comb
    begin
        chg_a = filt_next[0] != filt_reg[0];
        chg_b = filt_next[1] != filt_reg[1];
        up    = chg_a ? (filt_next[0] ^ filt_next[1]) : (filt_next[1] == filt_next[0]);
        counted = cnt_reg;
        if (chg_a ^ chg_b)
        begin
            if (up)
                counted = (cnt_reg == max_count) ? '0 : cnt_reg + WIDTH'(1);
            else
                counted = (cnt_reg == '0) ? max_count : cnt_reg - WIDTH'(1);
        end
    end

    assign count = counted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
            run_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (ctl.step)
        begin
            filt_reg <= filt_next;
            run_reg  <= run_next;
            cnt_reg  <= ctl.clear ? '0 : counted;
        end
    end

endmodule

/* hdl/qenc_merge.sv */
`timescale 1ns / 1ps
// Merging stage: sign-extends and optionally negates every lane count into the
// registered deltas of one report. Depends on qenc_pkg for widths.
module qenc_merge
    import qenc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           load,
    input  logic [NCH-1:0][WIDE_OUT-1:0]   snap,
    input  logic [NCH-1:0]                 invert,
    output logic signed [WIDE_OUT-1:0]     delta_ch0,
    output logic signed [NARROW_OUT-1:0]   delta_ch1,
    output logic signed [WIDE_OUT-1:0]     delta_ch2,
    output logic signed [NARROW_OUT-1:0]   delta_ch3
);

    logic signed [WIDE_OUT-1:0]   w0;
    logic signed [WIDE_OUT-1:0]   w2;
    logic signed [NARROW_OUT-1:0] n1;
    logic signed [NARROW_OUT-1:0] n3;
    logic signed [WIDE_OUT-1:0]   d0_reg;
    logic signed [NARROW_OUT-1:0] d1_reg;
    logic signed [WIDE_OUT-1:0]   d2_reg;
    logic signed [NARROW_OUT-1:0] d3_reg;

    // Negation wraps at the delta width, so the most negative wide value maps to itself.
    always_comb
    begin
        w0 = WIDE_OUT'(signed'(snap[0][COUNTER_BITS-1:0]));
        w2 = WIDE_OUT'(signed'(snap[2][COUNTER_BITS-1:0]));
        n1 = NARROW_OUT'(signed'(snap[1][NARROW_BITS-1:0]));
        n3 = NARROW_OUT'(signed'(snap[3][NARROW_BITS-1:0]));
        if (invert[0])
            w0 = -w0;
        if (invert[1])
            n1 = -n1;
        if (invert[2])
            w2 = -w2;
        if (invert[3])
            n3 = -n3;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            d0_reg <= w0;
            d1_reg <= n1;
            d2_reg <= w2;
            d3_reg <= n3;
        end
    end

    assign delta_ch0 = d0_reg;
    assign delta_ch1 = d1_reg;
    assign delta_ch2 = d2_reg;
    assign delta_ch3 = d3_reg;

endmodule

/* bench/quad_encoder_counter_snapshot_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the four-channel quadrature encoder counter.
// Depends on qenc_pkg and quad_encoder_counter_snapshot_unit; no other files are read.
module quad_encoder_counter_snapshot_unit_test;
    import qenc_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;

    typedef struct packed {
        logic [WIDE_OUT-1:0]   d0;
        logic [NARROW_OUT-1:0] d1;
        logic [WIDE_OUT-1:0]   d2;
        logic [NARROW_OUT-1:0] d3;
    } snapshot_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          func;
    logic [NCH-1:0]                phase_a_levels;
    logic [NCH-1:0]                phase_b_levels;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [WIDE_OUT-1:0]    delta_ch0;
    logic signed [NARROW_OUT-1:0]  delta_ch1;
    logic signed [WIDE_OUT-1:0]    delta_ch2;
    logic signed [NARROW_OUT-1:0]  delta_ch3;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;

    // Predictor state of the block.
    logic [31:0]    wrap_limit [NCH];
    logic [NCH-1:0] invert_bits;
    logic [31:0]    position [NCH];
    logic [1:0]     filtered [NCH];      // bit 0 is phase A, bit 1 is phase B
    int unsigned    run_length [2*NCH];

    snapshot_t pending_snapshots [$];
    logic [1:0] wheel_pos [NCH];         // quadrature position the stimulus aims for

    int  mismatches;
    int  samples_sent;
    int  snapshots_checked;
    int  settings_used;
    bit  calm_run;

    quad_encoder_counter_snapshot_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .phase_a_levels (phase_a_levels),
        .phase_b_levels (phase_b_levels),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .delta_ch0      (delta_ch0),
        .delta_ch1      (delta_ch1),
        .delta_ch2      (delta_ch2),
        .delta_ch3      (delta_ch3),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ---------------- predictor ----------------

    function automatic void reset_encoder_model();
        wrap_limit[0] = 32'hFFFF_FFFF;
        wrap_limit[1] = 32'h0000_FFFF;
        wrap_limit[2] = 32'hFFFF_FFFF;
        wrap_limit[3] = 32'h0000_FFFF;
        invert_bits = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            position[ch] = '0;
            filtered[ch] = '0;
        end
        for (int i = 0; i < 2*NCH; i++)
            run_length[i] = 0;
    endfunction

    // A new level is taken on the eighth differing sample in a row.
    function automatic logic debounce_phase(input int idx, input logic cur, input logic raw);
        if (raw == cur)
        begin
            run_length[idx] = 0;
            return cur;
        end
        if (run_length[idx] + 1 >= FILTER_SAMPLES_DEF)
        begin
            run_length[idx] = 0;
            return raw;
        end
        run_length[idx]++;
        return cur;
    endfunction

    function automatic void step_position(input int ch, input logic up);
        logic [31:0] m;
        logic [31:0] mx;
        logic [31:0] c;
        m  = ch[0] ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        mx = wrap_limit[ch] & m;
        c  = position[ch] & m;
        if (up)
            c = (c == mx) ? 32'h0 : ((c + 32'd1) & m);
        else
            c = (c == 32'h0) ? mx : ((c - 32'd1) & m);
        position[ch] = c;
    endfunction

    function automatic void advance_encoders(input logic want_snapshot,
                                             input logic [NCH-1:0] a,
                                             input logic [NCH-1:0] b);
        logic      oa;
        logic      ob;
        logic      na;
        logic      nb;
        snapshot_t snap;
        logic [NARROW_OUT-1:0] s;
        logic [WIDE_OUT-1:0]   v;
        for (int ch = 0; ch < NCH; ch++)
        begin
            oa = filtered[ch][0];
            ob = filtered[ch][1];
            na = debounce_phase(2*ch, oa, a[ch]);
            nb = debounce_phase(2*ch + 1, ob, b[ch]);
            filtered[ch] = {nb, na};
            // A tick where both filtered phases move is ambiguous and counts nothing.
            if (na != oa && nb == ob)
                step_position(ch, na ^ nb);
            else if (nb != ob && na == oa)
                step_position(ch, nb == na);
        end
        if (!want_snapshot)
            return;
        for (int ch = 0; ch < NCH; ch++)
        begin
            if (ch[0])
            begin
                s = {position[ch][15], position[ch][15:0]};
                if (invert_bits[ch])
                    s = ~s + 1'b1;
                if (ch == 1)
                    snap.d1 = s;
                else
                    snap.d3 = s;
            end
            else
            begin
                v = position[ch];
                if (invert_bits[ch])
                    v = ~v + 1'b1;
                if (ch == 0)
                    snap.d0 = v;
                else
                    snap.d2 = v;
            end
            position[ch] = '0;
        end
        pending_snapshots.push_back(snap);
    endfunction

    // ---------------- drivers ----------------

    task automatic send_sample(input logic want_snapshot,
                               input logic [NCH-1:0] a,
                               input logic [NCH-1:0] b);
        if (!calm_run && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= want_snapshot;
        phase_a_levels <= a;
        phase_b_levels <= b;
        do @(posedge clk); while (in_stall);
        advance_encoders(want_snapshot, a, b);
        samples_sent++;
    endtask

    task automatic hold_levels(input logic [NCH-1:0] a, input logic [NCH-1:0] b,
                               input int ticks, input logic snapshot_last);
        for (int t = 0; t < ticks; t++)
            send_sample(snapshot_last && (t == ticks - 1), a, b);
    endtask

    task automatic pause_for_snapshots();
        if (pending_snapshots.size() != 0)
        begin
            in_valid <= 1'b0;
            while (pending_snapshots.size() != 0)
                @(posedge clk);
        end
    endtask

    // Registers change only with no transaction in flight inside the block.
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        while (pending_snapshots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MAX_CH0: wrap_limit[0] = value;
            REG_MAX_CH1: wrap_limit[1] = {16'h0, value[15:0]};
            REG_MAX_CH2: wrap_limit[2] = value;
            REG_MAX_CH3: wrap_limit[3] = {16'h0, value[15:0]};
            REG_INVERT:  invert_bits   = value[NCH-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [31:0] l0, input logic [31:0] l1,
                                  input logic [31:0] l2, input logic [31:0] l3,
                                  input logic [31:0] inv);
        write_register(REG_MAX_CH0, l0);
        write_register(REG_MAX_CH1, l1);
        write_register(REG_MAX_CH2, l2);
        write_register(REG_MAX_CH3, l3);
        write_register(REG_INVERT, inv);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Narrow limits carry random upper bits that the block must drop.
    function automatic logic [31:0] pick_limit(input bit narrow);
        logic [31:0] m;
        logic [31:0] val;
        m = narrow ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        case ($urandom_range(0, 5))
            0:       val = 32'h0;
            1:       val = m;
            2:       val = $urandom_range(1, 6);
            3:       val = $urandom() & m;
            4:       val = $urandom_range(2, 20);
            default: val = 32'h1;
        endcase
        if (narrow)
            val = val | ($urandom() & 32'hFFFF_0000);
        return val;
    endfunction

    function automatic logic [2*NCH-1:0] wheel_levels();
        logic [NCH-1:0] a;
        logic [NCH-1:0] b;
        for (int ch = 0; ch < NCH; ch++)
        begin
            a[ch] = wheel_pos[ch][1] ^ wheel_pos[ch][0];
            b[ch] = wheel_pos[ch][1];
        end
        return {b, a};
    endfunction

    // Mostly clean quadrature motion held past the filter, plus glitches and noise.
    task automatic run_encoder_traffic(input int n_items);
        int             sent;
        int             hold;
        int             kind;
        logic [NCH-1:0] a;
        logic [NCH-1:0] b;
        sent = 0;
        for (int ch = 0; ch < NCH; ch++)
            wheel_pos[ch] = {filtered[ch][1], filtered[ch][0] ^ filtered[ch][1]};
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7:  wheel_pos[ch] = wheel_pos[ch] + 2'd1;
                        8, 9, 10, 11, 12, 13, 14: wheel_pos[ch] = wheel_pos[ch] - 2'd1;
                        15:                       wheel_pos[ch] = wheel_pos[ch] + 2'd2;
                        default: ;
                    endcase
                end
                {b, a} = wheel_levels();
                hold = $urandom_range(8, 14);
            end
            else if (kind < 85)
            begin
                {b, a} = wheel_levels();
                a = a ^ NCH'($urandom());
                b = b ^ NCH'($urandom());
                hold = $urandom_range(1, 7);
            end
            else
                hold = $urandom_range(1, 5);
            for (int t = 0; t < hold && sent < n_items; t++)
            begin
                if (kind >= 85)
                begin
                    a = NCH'($urandom());
                    b = NCH'($urandom());
                end
                send_sample($urandom_range(0, 9) == 0, a, b);
                sent++;
            end
        end
    endtask

    // ---------------- result checking ----------------

    initial
    begin : snapshot_checker
        snapshot_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_snapshots.size() == 0)
                    note_mismatch("snapshot transaction with none expected");
                else
                begin
                    want = pending_snapshots.pop_front();
                    snapshots_checked++;
                    if (delta_ch0 !== want.d0)
                        note_mismatch($sformatf("delta_ch0 expected %h got %h",
                                                want.d0, delta_ch0));
                    if (delta_ch1 !== want.d1)
                        note_mismatch($sformatf("delta_ch1 expected %h got %h",
                                                want.d1, delta_ch1));
                    if (delta_ch2 !== want.d2)
                        note_mismatch($sformatf("delta_ch2 expected %h got %h",
                                                want.d2, delta_ch2));
                    if (delta_ch3 !== want.d3)
                        note_mismatch($sformatf("delta_ch3 expected %h got %h",
                                                want.d3, delta_ch3));
                end
            end
        end
    end

    initial
    begin : receiver_stall
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm_run && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_snapshot();
        hold_levels('0, '0, 1, 1'b1);
    endtask

    // Seven samples are not enough, an equal sample restarts the run, the eighth commits.
    task automatic test_filter_and_direction();
        hold_levels('1, '0, 7, 1'b0);
        hold_levels('0, '0, 1, 1'b0);
        hold_levels('1, '0, 8, 1'b1);
        hold_levels('0, '1, 8, 1'b1);
        // Counting down from zero loads the reset limits.
        hold_levels('1, '1, 8, 1'b1);
    endtask

    task automatic test_limit_extremes();
        logic [NCH-1:0] all_inverted;
        all_inverted = '1;
        wait_until_quiet();
        apply_settings(32'h8000_0000, 32'hA5A5_8000, 32'h0, 32'h5A5A_FFFF,
                       32'(all_inverted));
        hold_levels('1, '0, 8, 1'b1);
        hold_levels('0, '0, 8, 1'b0);
        // Channel 1 and 3 limits drop below the held counts, so the next step up runs over them.
        wait_until_quiet();
        write_register(REG_MAX_CH1, 32'h0000_0002);
        write_register(REG_MAX_CH3, 32'hFFFF_0003);
        for (int k = int'(REG_INVERT) + 1; k < (1 << CFG_INDEX_BITS); k++)
            write_register(CFG_INDEX_BITS'(k), $urandom());
        cfg_valid <= 1'b0;
        hold_levels('1, '0, 8, 1'b1);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_until_quiet();
            case (phase)
                2:       apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'h0000_FFFF, 32'h0000_000F);
                3:       apply_settings(32'h1, 32'h0, pick_limit(1'b0), 32'hFFFF_FFFF,
                                        $urandom());
                default: apply_settings(pick_limit(1'b0), pick_limit(1'b1),
                                        pick_limit(1'b0), pick_limit(1'b1), $urandom());
            endcase
            if (phase == 3)
                calm_run = 1'b1;
            if (phase == 1)
            begin
                run_encoder_traffic(170);
                pause_for_snapshots();
                run_encoder_traffic(175);
            end
            else
                run_encoder_traffic(345);
        end
    endtask

    initial
    begin : main_sequence
        int waited;
        in_valid       <= 1'b0;
        func           <= 1'b0;
        phase_a_levels <= '0;
        phase_b_levels <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_MAX_CH0;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        mismatches        = 0;
        samples_sent      = 0;
        snapshots_checked = 0;
        settings_used     = 1;
        calm_run          = 1'b0;
        reset_encoder_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_snapshot();
        test_filter_and_direction();
        test_limit_extremes();
        test_random_settings();

        in_valid <= 1'b0;
        for (waited = 0; waited < DRAIN_LIMIT && pending_snapshots.size() != 0; waited++)
            @(posedge clk);
        while (pending_snapshots.size() != 0)
        begin
            void'(pending_snapshots.pop_front());
            note_mismatch("expected snapshot never arrived");
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d sample transactions under %0d register settings;",
                 samples_sent, settings_used);
        $display("compared %0d snapshots, %0d mismatches.", snapshots_checked, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
